[hdl/assert_macros.svh]
// Assertion macros shared by the scheduler RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, checks off during reset
`define ASSERT_IMP(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("scheduler assertion failed");

// Implication into the next cycle, also active across reset
`define ASSERT_NXT(lbl, clk, a, b) \
  lbl: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("scheduler assertion failed");

`endif

[hdl/mlfq_pkg.sv]
// Package for the multilevel feedback queue scheduler.
// Holds default sizes, command and register codes, and shared structs.
package mlfq_pkg;

  localparam int MAX_PROCS_DEF  = 32;
  localparam int MAX_LEVELS_DEF = 4;

  localparam int TIME_W   = 16;
  localparam int ID_OUT_W = 5;
  localparam int CMD_W    = 2;
  localparam int NLVL_W   = 3;
  localparam int CFG_IDX_W = 2;

  // Request commands
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ARRIVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_LEVELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM0   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM1   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM2   = 2'd3;

  localparam logic [TIME_W-1:0] SLICE_MAX = 16'hFFFF;

  typedef struct packed {
    logic [NLVL_W-1:0] num_levels;
    logic [TIME_W-1:0] quantum0;
    logic [TIME_W-1:0] quantum1;
    logic [TIME_W-1:0] quantum2;
  } cfg_t;

  // Queued request from front to back
  typedef struct packed {
    logic              valid;
    logic [CMD_W-1:0]  cmd;
    logic [TIME_W-1:0] burst;
  } req_t;

endpackage

[hdl/mlfq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mlfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/mlfq_front.sv]
// Front end: accepts requests, drops unused commands, buffers two deep.
// Depends on mlfq_pkg.
module mlfq_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mlfq_pkg::CMD_W-1:0]  cmd,
  input  logic [mlfq_pkg::TIME_W-1:0] burst,
  output mlfq_pkg::req_t              req,
  input  logic                        req_pop
);

  logic [mlfq_pkg::CMD_W-1:0]  e_cmd   [2];
  logic [mlfq_pkg::TIME_W-1:0] e_burst [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       push;
  logic       pop;
  logic       known;

  // Classify: only tick, arrival and query reach the back end
  always_comb begin
    known = (cmd inside {mlfq_pkg::CMD_TICK, mlfq_pkg::CMD_ARRIVE, mlfq_pkg::CMD_QUERY});
  end

  assign in_ready  = (cnt != 2'd2);
  assign push      = in_valid && in_ready && known;
  assign pop       = req_pop && (cnt != 2'd0);
  assign req.valid = (cnt != 2'd0);
  assign req.cmd   = e_cmd[rd_ptr];
  assign req.burst = e_burst[rd_ptr];

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  // Payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      e_cmd[wr_ptr]   <= cmd;
      e_burst[wr_ptr] <= burst;
    end
  end

endmodule

[hdl/mlfq_back.sv]
// Back end: runs ticks, arrivals and queries against the level queues.
// Depends on mlfq_pkg and mlfq_ram.
module mlfq_back #(
  parameter int MAX_PROCS  = mlfq_pkg::MAX_PROCS_DEF,
  parameter int MAX_LEVELS = mlfq_pkg::MAX_LEVELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mlfq_pkg::cfg_t                cfg,
  input  mlfq_pkg::req_t                req,
  output logic                          req_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          kind,
  output logic [mlfq_pkg::ID_OUT_W-1:0] proc_id,
  output logic [mlfq_pkg::TIME_W-1:0]   remaining,
  output logic                          rejected,
  output logic                          last
);

  localparam int IDW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW  = $clog2(MAX_PROCS + 1);
  localparam int LW  = $clog2(MAX_LEVELS);
  localparam int QD  = MAX_LEVELS * MAX_PROCS;
  localparam int QAW = $clog2(QD);
  localparam int TW  = mlfq_pkg::TIME_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TQ   = 4'd1;
  localparam logic [3:0] S_TID  = 4'd2;
  localparam logic [3:0] S_TEX  = 4'd3;
  localparam logic [3:0] S_ARQ  = 4'd4;
  localparam logic [3:0] S_ARW  = 4'd5;
  localparam logic [3:0] S_AEM  = 4'd6;
  localparam logic [3:0] S_REJ  = 4'd7;
  localparam logic [3:0] S_QRD  = 4'd8;
  localparam logic [3:0] S_QEM  = 4'd9;

  logic [3:0]     state;
  logic [IDW-1:0] head [MAX_LEVELS];
  logic [IDW-1:0] tail [MAX_LEVELS];
  logic [CW-1:0]  fill [MAX_LEVELS];
  logic [LW-1:0]  cur;
  logic [TW-1:0]  slice;
  logic [CW-1:0]  count;
  logic [LW-1:0]  lv_r;
  logic [IDW-1:0] id_r;
  logic [IDW-1:0] idx_r;
  logic [TW-1:0]  burst_r;

  logic           lq_we;
  logic [QAW-1:0] lq_waddr;
  logic [IDW-1:0] lq_wdata;
  logic [QAW-1:0] lq_raddr;
  logic [IDW-1:0] lq_rdata;
  logic           rt_we;
  logic [IDW-1:0] rt_waddr;
  logic [TW-1:0]  rt_wdata;
  logic [IDW-1:0] rt_raddr;
  logic [TW-1:0]  rt_rdata;

  logic           any_ne;
  logic [LW-1:0]  first_lv;
  logic           full;
  logic           arr_ok;
  logic           rot;
  logic           slot_free;
  logic           res_load;
  logic           q_last;
  logic [TW-1:0]  s_base;
  logic [TW-1:0]  s_n;
  logic [TW-1:0]  rem_n;
  logic [TW-1:0]  quant;
  logic [mlfq_pkg::NLVL_W-1:0] nl;
  logic [mlfq_pkg::NLVL_W-1:0] last_lv;
  logic           done_t;
  logic           demote;
  logic [LW-1:0]  lv_dn;

  function automatic logic [IDW-1:0] ring_next(input logic [IDW-1:0] x);
    return (x == IDW'(MAX_PROCS - 1)) ? '0 : x + IDW'(1);
  endfunction

  function automatic logic [QAW-1:0] qaddr(input logic [LW-1:0] lv,
                                           input logic [IDW-1:0] ptr);
    return QAW'(QAW'(lv) * QAW'(MAX_PROCS)) + QAW'(ptr);
  endfunction

  function automatic logic [mlfq_pkg::ID_OUT_W-1:0] id_out(input logic [IDW-1:0] id);
    logic [IDW+mlfq_pkg::ID_OUT_W-1:0] ext;
    ext = {{mlfq_pkg::ID_OUT_W{1'b0}}, id};
    return ext[mlfq_pkg::ID_OUT_W-1:0];
  endfunction

  mlfq_ram #(.WIDTH(IDW), .DEPTH(QD)) u_lq_ram (
    .clk   (clk),
    .we    (lq_we),
    .waddr (lq_waddr),
    .wdata (lq_wdata),
    .raddr (lq_raddr),
    .rdata (lq_rdata)
  );

  mlfq_ram #(.WIDTH(TW), .DEPTH(MAX_PROCS)) u_rt_ram (
    .clk   (clk),
    .we    (rt_we),
    .waddr (rt_waddr),
    .wdata (rt_wdata),
    .raddr (rt_raddr),
    .rdata (rt_rdata)
  );

  // Highest-priority non-empty level
  always_comb begin
    any_ne   = 1'b0;
    first_lv = '0;
    for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
      if (fill[i] != '0) begin
        any_ne   = 1'b1;
        first_lv = LW'(i);
      end
    end
  end

  // Tick arithmetic on the running process
  always_comb begin
    nl = cfg.num_levels;
    if (nl < 3'd2) begin
      nl = 3'd2;
    end
    if (nl > 3'(MAX_LEVELS)) begin
      nl = 3'(MAX_LEVELS);
    end
    last_lv = nl - 3'd1;
    case (lv_r)
      LW'(0):  quant = cfg.quantum0;
      LW'(1):  quant = cfg.quantum1;
      default: quant = cfg.quantum2;
    endcase
    if (quant == '0) begin
      quant = TW'(1);
    end
    s_base = (lv_r != cur) ? '0 : slice;
    s_n    = (s_base == mlfq_pkg::SLICE_MAX) ? s_base : s_base + TW'(1);
    rem_n  = (rt_rdata != '0) ? rt_rdata - TW'(1) : rt_rdata;
    done_t = (rem_n == '0);
    demote = !done_t && (3'(lv_r) < last_lv) && (s_n == quant);
    lv_dn  = lv_r + LW'(1);
  end

  assign full      = (count >= CW'(MAX_PROCS));
  assign arr_ok    = (state == S_IDLE) && req.valid && (req.cmd == mlfq_pkg::CMD_ARRIVE) &&
                     !full;
  assign rot       = (cur != '0) && (slice != '0) && (fill[cur] != '0);
  assign slot_free = !out_valid || out_ready;
  assign res_load  = slot_free && (state inside {S_AEM, S_REJ, S_QEM});
  assign q_last    = ((CW'(idx_r) + CW'(1)) == count);
  assign req_pop   = (state == S_IDLE) && req.valid;

  // Memory port steering
  always_comb begin
    lq_we    = 1'b0;
    lq_waddr = qaddr('0, tail[0]);
    lq_wdata = idx_r;
    if (arr_ok && (req.burst != '0)) begin
      lq_we    = 1'b1;
      lq_waddr = qaddr('0, tail[0]);
      lq_wdata = count[IDW-1:0];
    end else if ((state == S_TEX) && demote) begin
      lq_we    = 1'b1;
      lq_waddr = qaddr(lv_dn, tail[lv_dn]);
      lq_wdata = id_r;
    end else if (state == S_ARW) begin
      lq_we    = 1'b1;
      lq_waddr = qaddr(cur, tail[cur]);
      lq_wdata = lq_rdata;
    end
    lq_raddr = (state == S_ARQ) ? qaddr(cur, head[cur]) : qaddr(lv_r, head[lv_r]);

    rt_we    = 1'b0;
    rt_waddr = id_r;
    rt_wdata = rem_n;
    if (arr_ok) begin
      rt_we    = 1'b1;
      rt_waddr = count[IDW-1:0];
      rt_wdata = req.burst;
    end else if (state == S_TEX) begin
      rt_we    = 1'b1;
    end
    rt_raddr = (state == S_TID) ? lq_rdata : idx_r;
  end

  // Sequencer and queue bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur       <= '0;
      slice     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        fill[i] <= '0;
      end
    end else begin
      // output register: load a new result or clear once taken
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            case (req.cmd)
              mlfq_pkg::CMD_TICK: begin
                if (any_ne) begin
                  lv_r  <= first_lv;
                  state <= S_TQ;
                end
              end
              mlfq_pkg::CMD_ARRIVE: begin
                if (full) begin
                  state <= S_REJ;
                end else begin
                  idx_r   <= count[IDW-1:0];
                  burst_r <= req.burst;
                  count   <= count + CW'(1);
                  if (req.burst != '0) begin
                    tail[0] <= ring_next(tail[0]);
                    fill[0] <= fill[0] + CW'(1);
                  end
                  if (rot) begin
                    state <= S_ARQ;
                  end else begin
                    // level 0 keeps its slice; a lower level is preempted
                    if (cur != '0) begin
                      cur   <= '0;
                      slice <= '0;
                    end
                    state <= S_AEM;
                  end
                end
              end
              mlfq_pkg::CMD_QUERY: begin
                if (count != '0) begin
                  idx_r <= '0;
                  state <= S_QRD;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_TQ: begin
          state <= S_TID;
        end
        S_TID: begin
          id_r  <= lq_rdata;
          state <= S_TEX;
        end
        S_TEX: begin
          cur <= lv_r;
          if (done_t || demote) begin
            head[lv_r] <= ring_next(head[lv_r]);
            fill[lv_r] <= fill[lv_r] - CW'(1);
            slice      <= '0;
          end else begin
            slice <= s_n;
          end
          if (demote) begin
            tail[lv_dn] <= ring_next(tail[lv_dn]);
            fill[lv_dn] <= fill[lv_dn] + CW'(1);
          end
          state <= S_IDLE;
        end
        S_ARQ: begin
          state <= S_ARW;
        end
        S_ARW: begin
          // rotate the preempted head to the tail of its own level
          head[cur] <= ring_next(head[cur]);
          tail[cur] <= ring_next(tail[cur]);
          cur       <= '0;
          slice     <= '0;
          state     <= S_AEM;
        end
        S_AEM: begin
          if (slot_free) begin
            kind      <= 1'b0;
            proc_id   <= id_out(idx_r);
            remaining <= burst_r;
            rejected  <= 1'b0;
            last      <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_REJ: begin
          if (slot_free) begin
            kind      <= 1'b0;
            proc_id   <= '0;
            remaining <= '0;
            rejected  <= 1'b1;
            last      <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_QRD: begin
          state <= S_QEM;
        end
        S_QEM: begin
          if (slot_free) begin
            kind      <= 1'b1;
            proc_id   <= id_out(idx_r);
            remaining <= rt_rdata;
            rejected  <= 1'b0;
            last      <= q_last;
            if (q_last) begin
              state <= S_IDLE;
            end else begin
              idx_r <= idx_r + IDW'(1);
              state <= S_QRD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hdl/multilevel_feedback_queue_scheduler.sv]
// Multilevel feedback queue scheduler, top level.
// Requests enter on in_valid/in_ready with cmd (0 tick, 1 arrival, 2 query)
// and burst. Results leave on out_valid/out_ready with kind, proc_id,
// remaining, rejected and last; last marks the final result of a request.
// A tick gives no result; an arrival gives one acknowledge (or a refusal
// when the process table is full); a query gives one entry per process.
// The front end buffers two requests, so requests are taken while the back
// end works or while a result waits in the output register.
// A tick runs through a queue read, an id read and an update; an arrival
// goes straight to its result, or first rotates a preempted process; a
// query emits one entry per process in turn. The queue and time memories
// have registered reads. A stalled receiver holds the result and pauses
// the back end; the front end fills and then drops in_ready.
// Reset clears all queues, counters and the configuration (3 levels,
// quanta 4, 8, 16); the memories need no clearing pass.
// Depends on mlfq_pkg, mlfq_front, mlfq_back, mlfq_ram, assert_macros.svh.
`include "assert_macros.svh"

module multilevel_feedback_queue_scheduler #(
  parameter int MAX_PROCS  = mlfq_pkg::MAX_PROCS_DEF,
  parameter int MAX_LEVELS = mlfq_pkg::MAX_LEVELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mlfq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mlfq_pkg::TIME_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mlfq_pkg::CMD_W-1:0]     cmd,
  input  logic [mlfq_pkg::TIME_W-1:0]    burst,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           kind,
  output logic [mlfq_pkg::ID_OUT_W-1:0]  proc_id,
  output logic [mlfq_pkg::TIME_W-1:0]    remaining,
  output logic                           rejected,
  output logic                           last
);

  mlfq_pkg::cfg_t cfg;
  mlfq_pkg::req_t req;
  logic           req_pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_levels <= 3'd3;
      cfg.quantum0   <= 16'd4;
      cfg.quantum1   <= 16'd8;
      cfg.quantum2   <= 16'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        mlfq_pkg::CFG_NUM_LEVELS: cfg.num_levels <= cfg_data[mlfq_pkg::NLVL_W-1:0];
        mlfq_pkg::CFG_QUANTUM0:   cfg.quantum0   <= cfg_data;
        mlfq_pkg::CFG_QUANTUM1:   cfg.quantum1   <= cfg_data;
        mlfq_pkg::CFG_QUANTUM2:   cfg.quantum2   <= cfg_data;
        default:                  cfg.num_levels <= cfg.num_levels;
      endcase
    end
  end

  mlfq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .burst    (burst),
    .req      (req),
    .req_pop  (req_pop)
  );

  mlfq_back #(
    .MAX_PROCS  (MAX_PROCS),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req       (req),
    .req_pop   (req_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .proc_id   (proc_id),
    .remaining (remaining),
    .rejected  (rejected),
    .last      (last)
  );

  // Checks
  `ASSERT_IMP(a_rej_form, clk, rst, out_valid && rejected, !kind && last && remaining == '0)
  `ASSERT_IMP(a_query_ok, clk, rst, out_valid && kind, !rejected)
  `ASSERT_NXT(a_rst_idle, clk, rst, !out_valid)

endmodule

[sim/multilevel_feedback_queue_scheduler_tb.sv]
// Testbench for the multilevel feedback queue scheduler: directed and random
// request streams checked against a local scheduling model in a scoreboard class.
// Depends on mlfq_pkg and the multilevel_feedback_queue_scheduler RTL.
`timescale 1ns / 1ps

module multilevel_feedback_queue_scheduler_tb;

  localparam int NPROC = 32;
  localparam int NLVL  = 4;
  localparam int WATCHDOG_LIMIT = 20000;
  // command code the block ignores
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [4:0]  proc_id;
    logic [15:0] remaining;
    logic        rejected;
    logic        last;
  } sched_result_t;

  // Scheduling model with its own copy of state, plus expected results
  class sched_scoreboard;
    logic [2:0]  levels_cfg;
    logic [15:0] quantum[3];
    logic [15:0] rem_time[NPROC];
    logic [4:0]  ring[NLVL][NPROC];
    int          head[NLVL], tail[NLVL], fill[NLVL];
    int          cur_level;
    int          slice;
    int          procs;
    sched_result_t pending[$];
    int          mismatches;
    int          results_seen;

    function new();
      levels_cfg = 3'd3;
      quantum[0] = 16'd4; quantum[1] = 16'd8; quantum[2] = 16'd16;
      for (int l = 0; l < NLVL; l++) begin
        head[l] = 0; tail[l] = 0; fill[l] = 0;
      end
      cur_level = 0; slice = 0; procs = 0;
      mismatches = 0; results_seen = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        mlfq_pkg::CFG_NUM_LEVELS: levels_cfg = val[2:0];
        mlfq_pkg::CFG_QUANTUM0:   quantum[0] = val;
        mlfq_pkg::CFG_QUANTUM1:   quantum[1] = val;
        default:                  quantum[2] = val;
      endcase
    endfunction

    function void push(int lv, logic [4:0] id);
      if (fill[lv] >= NPROC) return;
      ring[lv][tail[lv]] = id;
      tail[lv] = (tail[lv] + 1) % NPROC;
      fill[lv]++;
    endfunction

    function logic [4:0] pop(int lv);
      logic [4:0] id;
      id = ring[lv][head[lv]];
      head[lv] = (head[lv] + 1) % NPROC;
      fill[lv]--;
      return id;
    endfunction

    function void run_tick();
      int lv, lastlv, q;
      logic [4:0] id;
      lv = 0;
      while (lv < NLVL && fill[lv] == 0) lv++;
      if (lv >= NLVL) return;
      if (lv != cur_level) slice = 0;
      cur_level = lv;
      id = ring[lv][head[lv]];
      if (rem_time[id] != 0) rem_time[id]--;
      if (slice < 65535) slice++;
      lastlv = (levels_cfg < 2) ? 1 : (levels_cfg > NLVL) ? NLVL - 1 : levels_cfg - 1;
      q = (lv == 0) ? quantum[0] : (lv == 1) ? quantum[1] : quantum[2];
      if (q == 0) q = 1;
      if (rem_time[id] == 0) begin
        void'(pop(lv));
        slice = 0;
      end else if (lv < lastlv && slice == q) begin
        push(lv + 1, pop(lv));
        slice = 0;
      end
    endfunction

    // Note an accepted request and queue up what it should produce
    function void note_request(logic [1:0] c, logic [15:0] b);
      sched_result_t r;
      case (c)
        mlfq_pkg::CMD_TICK: run_tick();
        mlfq_pkg::CMD_ARRIVE: begin
          if (procs >= NPROC) begin
            r = '{1'b0, 5'd0, 16'd0, 1'b1, 1'b1};
          end else begin
            rem_time[procs] = b;
            if (b != 0) push(0, procs[4:0]);
            if (cur_level != 0) begin
              if (slice != 0 && fill[cur_level] != 0) push(cur_level, pop(cur_level));
              slice = 0;
              cur_level = 0;
            end
            r = '{1'b0, procs[4:0], b, 1'b0, 1'b1};
            procs++;
          end
          pending.insert(pending.size(), r);
        end
        mlfq_pkg::CMD_QUERY: begin
          for (int i = 0; i < procs; i++) begin
            r = '{1'b1, i[4:0], rem_time[i], 1'b0, (i + 1 == procs)};
            pending.insert(pending.size(), r);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(sched_result_t got);
      sched_result_t want;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid, in_ready;
  logic [1:0]  cmd;
  logic [15:0] burst;
  logic        out_valid, out_ready;
  logic        kind, rejected, last;
  logic [4:0]  proc_id;
  logic [15:0] remaining;

  sched_scoreboard sb;
  int  idle_cycles;
  int  requests_sent;
  bit  hold_off;

  multilevel_feedback_queue_scheduler dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .burst(burst),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .proc_id(proc_id),
    .remaining(remaining), .rejected(rejected), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Send one request, with a random gap in front; valid stays up on no gap
  task automatic send_request(logic [1:0] c, logic [15:0] b);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    burst <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(c, b);
    requests_sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // Wait for all results, then let a tick still in flight settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Fresh phase: settings applied while idle
  task automatic set_config(logic [15:0] nl, logic [15:0] q0, logic [15:0] q1,
                            logic [15:0] q2);
    drain();
    write_reg(mlfq_pkg::CFG_NUM_LEVELS, nl);
    write_reg(mlfq_pkg::CFG_QUANTUM0, q0);
    write_reg(mlfq_pkg::CFG_QUANTUM1, q1);
    write_reg(mlfq_pkg::CFG_QUANTUM2, q2);
    cfg_we <= 1'b0;
  endtask

  // Random phase: mostly ticks and arrivals with small bursts
  task automatic random_phase(int n);
    int sel;
    logic [15:0] b;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      b = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
      if (sel < 55) send_request(mlfq_pkg::CMD_TICK, 16'($urandom));
      else if (sel < 80) send_request(mlfq_pkg::CMD_ARRIVE, b);
      else if (sel < 95) send_request(mlfq_pkg::CMD_QUERY, 16'($urandom));
      else send_request(CMD_UNUSED, 16'($urandom));
    end
  endtask

  // Receiver: a drawn wait before each result, plus one long hold-off when asked
  initial begin
    int wait_n;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      wait_n = ($urandom_range(0, 2) != 0) ? 0 : $urandom_range(0, 19);
      if (wait_n != 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result('{kind, proc_id, remaining, rejected, last});
    end
  end

  // Watchdog on cycles without any handshake
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || hold_off) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = mlfq_pkg::CFG_NUM_LEVELS; cfg_data = '0;
    in_valid = 1'b0; cmd = mlfq_pkg::CMD_TICK; burst = '0;
    hold_off = 1'b0; requests_sent = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty tick, empty query, extremes, zero burst, unused command
    send_request(mlfq_pkg::CMD_TICK, 16'd0);
    send_request(mlfq_pkg::CMD_QUERY, 16'd0);
    send_request(CMD_UNUSED, 16'hFFFF);
    send_request(mlfq_pkg::CMD_ARRIVE, 16'd0);
    send_request(mlfq_pkg::CMD_ARRIVE, 16'hFFFF);
    send_request(mlfq_pkg::CMD_ARRIVE, 16'd6);
    for (int i = 0; i < 10; i++) send_request(mlfq_pkg::CMD_TICK, 16'($urandom));
    send_request(mlfq_pkg::CMD_ARRIVE, 16'd3);       // preempts a demoted process
    send_request(mlfq_pkg::CMD_ARRIVE, 16'hAAAA);
    send_request(mlfq_pkg::CMD_ARRIVE, 16'h5555);
    for (int i = 0; i < 5; i++) send_request(mlfq_pkg::CMD_TICK, 16'd0);
    send_request(mlfq_pkg::CMD_QUERY, 16'd0);

    // Zero quanta, out-of-range levels count
    set_config(16'd0, 16'd0, 16'd0, 16'd0);
    random_phase(40);
    set_config(16'd7, 16'd1, 16'd2, 16'd1);
    random_phase(40);

    // Long receiver stall while requests keep coming
    hold_off = 1'b1;
    for (int i = 0; i < 12; i++) send_request(mlfq_pkg::CMD_QUERY, 16'd0);
    set_config(16'd4, 16'd3, 16'd5, 16'd7);
    random_phase(60);
    set_config(16'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_phase(40);

    // Fill the table to reach refusals
    set_config(16'd3, 16'd2, 16'd4, 16'd8);
    for (int i = 0; i < 8; i++)
      send_request(mlfq_pkg::CMD_ARRIVE, 16'($urandom_range(1, 30)));
    random_phase(60);
    send_request(mlfq_pkg::CMD_QUERY, 16'd0);

    drain();
    $display("Covered %0d requests and %0d results over six register settings,",
             requests_sent, sb.results_seen);
    $display("including a full table, zero quanta and a long output stall.");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
